// File: design/hrsl_pkg.sv
// Shared types and codes for the hex record sector loader.
package hrsl_pkg;

	// Item action codes
	localparam logic [2:0] ACT_DATA = 3'd0;
	localparam logic [2:0] ACT_EOF  = 3'd1;
	localparam logic [2:0] ACT_SEG  = 3'd2;
	localparam logic [2:0] ACT_LIN  = 3'd3;

	localparam int unsigned ADDR_W   = 32;
	localparam int unsigned RECIP_W  = 27;   // reciprocal width, enough for a 64-byte sector
	localparam int unsigned SUM_W    = 17;   // record address + byte index
	localparam int unsigned PROD_W   = SUM_W + RECIP_W;
	localparam int unsigned QUO_W    = PROD_W - 32;
	localparam int unsigned DIV_W    = 13;   // holds a sector size of up to 4096

	typedef struct packed {
		logic capture;      // load input beat into item registers
		logic exec;         // decode item: start latch, offset write, modulo product
		logic store;        // write data byte into the sector buffer
		logic clear_wr;     // write 0xFF word at the word counter
		logic rd_en;        // read buffer word at the word counter
		logic out_load;     // load output register from read data
		logic w_clr;        // word counter to zero
		logic w_inc;        // word counter advance
		logic flush_clear;  // drop start address latch after a full sector
	} cmd_t;

	typedef struct packed {
		logic act_data;
		logic act_eof;
		logic sector_full;  // byte in store lands in the last slot
		logic w_last;       // word counter at the last word
		logic out_free;     // output register can take a word this cycle
	} stat_t;

endpackage

// File: design/hex_record_sector_loader.sv
// Top level of the hex record sector loader: controller plus datapath.
//
// Input channel (in_valid / in_stall) carries one unpacked record item per beat:
// action, record_address, byte_index, data_byte, address_value.
// Output channel (out_valid / out_stall) carries one 32-bit flash word per beat,
// with its sector start address, word index and a last-word flag.
//
// Steps from one accepted input beat to the next:
//   data byte that does not finish a sector:  accept, decode + modulo
//     product registered, back-multiply + buffer write
//   segment / linear / ignored record:        accept, decode
//   data byte that fills the sector:          accept, decode, store, flush
//   end of file:                              accept, decode, flush
// A flush reads each word from the buffer and then loads it into the output
// register before it reads the next. One item at a time.
// After reset a clearing pass over every buffer word fills the buffer
// with 0xFF, with in_stall high. A stalled output holds its beat; the flush
// pauses until the word is taken, and no words are dropped or repeated.
module hex_record_sector_loader #(
	parameter int unsigned SECTOR_BYTES = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  action,
	input  logic [15:0] record_address,
	input  logic [7:0]  byte_index,
	input  logic [7:0]  data_byte,
	input  logic [15:0] address_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] flash_address,
	output logic [5:0]  word_index,
	output logic [31:0] flash_word,
	output logic        last_word
);

	hrsl_pkg::cmd_t  cmd;
	hrsl_pkg::stat_t stat;

	// sequencing: accept, decode, store, flush loop, reset clearing sweep
	hrsl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// buffer, address latches, slot modulo and output register
	hrsl_datapath #(
		.SECTOR_BYTES (SECTOR_BYTES)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.action         (action),
		.record_address (record_address),
		.byte_index     (byte_index),
		.data_byte      (data_byte),
		.address_value  (address_value),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.flash_address  (flash_address),
		.word_index     (word_index),
		.flash_word     (flash_word),
		.last_word      (last_word)
	);

endmodule

// File: design/hrsl_ctrl.sv
// Controller state machine for the hex record sector loader.
module hrsl_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  hrsl_pkg::stat_t stat,
	output hrsl_pkg::cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC,
		ST_STORE,
		ST_EMIT_RD,
		ST_EMIT_LD
	} state_t;

	state_t state_q;
	logic   clear_mode_q;   // flush came from a full sector: wipe as we read

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_INIT;
			clear_mode_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_INIT: begin
					if (stat.w_last) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_valid) state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (stat.act_data) begin
						state_q <= ST_STORE;
					end else if (stat.act_eof) begin
						clear_mode_q <= 1'b0;
						state_q      <= ST_EMIT_RD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_STORE: begin
					if (stat.sector_full) begin
						clear_mode_q <= 1'b1;
						state_q      <= ST_EMIT_RD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT_RD: begin
					state_q <= ST_EMIT_LD;
				end
				ST_EMIT_LD: begin
					if (stat.out_free) begin
						state_q <= stat.w_last ? ST_IDLE : ST_EMIT_RD;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_INIT: begin
				cmd.clear_wr = 1'b1;
				cmd.w_inc    = !stat.w_last;
				cmd.w_clr    = stat.w_last;
			end
			ST_IDLE: begin
				cmd.capture = in_valid;
			end
			ST_EXEC: begin
				cmd.exec  = 1'b1;
				cmd.w_clr = 1'b1;
			end
			ST_STORE: begin
				cmd.store = 1'b1;
			end
			ST_EMIT_RD: begin
				cmd.rd_en    = 1'b1;
				cmd.clear_wr = clear_mode_q;
			end
			ST_EMIT_LD: begin
				cmd.out_load    = stat.out_free;
				cmd.w_inc       = stat.out_free && !stat.w_last;
				cmd.w_clr       = stat.out_free && stat.w_last;
				cmd.flush_clear = stat.out_free && stat.w_last && clear_mode_q;
			end
			default: cmd = '0;
		endcase
	end

endmodule

// File: design/hrsl_datapath.sv
// Datapath: item registers, slot modulo, sector buffer, address latches, output register.
module hrsl_datapath #(
	parameter int unsigned SECTOR_BYTES = 256
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  hrsl_pkg::cmd_t          cmd,
	output hrsl_pkg::stat_t         stat,
	input  logic [2:0]              action,
	input  logic [15:0]             record_address,
	input  logic [7:0]              byte_index,
	input  logic [7:0]              data_byte,
	input  logic [15:0]             address_value,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [31:0]             flash_address,
	output logic [5:0]              word_index,
	output logic [31:0]             flash_word,
	output logic                    last_word
);

	localparam int unsigned SectorWords = (SECTOR_BYTES + 3) / 4;
	localparam int unsigned WW          = $clog2(SectorWords);
	localparam int unsigned RW          = $clog2(SECTOR_BYTES);
	// ceil(2^32 / SECTOR_BYTES): floor(x * Recip / 2^32) is exact for 17-bit x
	localparam logic [63:0] RecipWide   =
		((64'd1 << 32) + 64'(SECTOR_BYTES) - 64'd1) / 64'(SECTOR_BYTES);
	localparam logic [hrsl_pkg::RECIP_W-1:0] Recip = RecipWide[hrsl_pkg::RECIP_W-1:0];
	localparam logic [hrsl_pkg::DIV_W-1:0]   Div   = hrsl_pkg::DIV_W'(SECTOR_BYTES);
	localparam logic [RW-1:0]                LastSlot = RW'(SECTOR_BYTES - 1);
	localparam logic [WW-1:0]                LastWord = WW'(SectorWords - 1);

	// item registers
	logic [2:0]  action_q;
	logic [15:0] rec_q;
	logic [7:0]  idx_q;
	logic [7:0]  data_q;
	logic [15:0] value_q;

	// architectural state
	logic [31:0] offset_q;
	logic [31:0] start_q;
	logic        latched_q;
	logic [WW-1:0] w_q;

	// slot modulo pipeline
	logic [hrsl_pkg::SUM_W-1:0]  sum;
	logic [hrsl_pkg::SUM_W-1:0]  sum_s1;
	logic [hrsl_pkg::PROD_W-1:0] prod_s1;
	logic [hrsl_pkg::QUO_W-1:0]  quo;
	logic [hrsl_pkg::QUO_W+hrsl_pkg::DIV_W-1:0] quo_div;
	logic [hrsl_pkg::SUM_W-1:0]  rem_full;
	logic [RW-1:0]               slot;

	// sector buffer, one 32-bit word per four slots
	logic [31:0]   mem [SectorWords];
	logic [31:0]   rdata_q;
	logic          mem_we;
	logic [WW-1:0] waddr;
	logic [3:0]    wbe;
	logic [31:0]   wdata;

	logic out_valid_q;
	logic out_free;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			action_q <= action;
			rec_q    <= record_address;
			idx_q    <= byte_index;
			data_q   <= data_byte;
			value_q  <= address_value;
		end
	end

	assign sum = {1'b0, rec_q} + {9'b0, idx_q};

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			sum_s1  <= sum;
			prod_s1 <= {{hrsl_pkg::RECIP_W{1'b0}}, sum} * {{hrsl_pkg::SUM_W{1'b0}}, Recip};
		end
	end

	assign quo      = prod_s1[hrsl_pkg::PROD_W-1:32];
	assign quo_div  = {{hrsl_pkg::DIV_W{1'b0}}, quo} * {{hrsl_pkg::QUO_W{1'b0}}, Div};
	assign rem_full = sum_s1 - quo_div[hrsl_pkg::SUM_W-1:0];
	assign slot     = rem_full[RW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q  <= '0;
			start_q   <= '0;
			latched_q <= 1'b0;
		end else if (cmd.flush_clear) begin
			start_q   <= '0;
			latched_q <= 1'b0;
		end else if (cmd.exec) begin
			priority case (action_q)
				hrsl_pkg::ACT_DATA: begin
					if (idx_q == 8'd0 && !latched_q) begin
						start_q   <= offset_q + {16'b0, rec_q};
						latched_q <= 1'b1;
					end
				end
				hrsl_pkg::ACT_SEG: offset_q <= {12'b0, value_q, 4'b0};
				hrsl_pkg::ACT_LIN: offset_q <= {value_q, 16'b0};
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= '0;
		end else if (cmd.w_clr) begin
			w_q <= '0;
		end else if (cmd.w_inc) begin
			w_q <= w_q + WW'(1);
		end
	end

	// write port: clearing sweep or single byte lane
	always_comb begin
		mem_we = cmd.clear_wr || cmd.store;
		if (cmd.clear_wr) begin
			waddr = w_q;
			wbe   = 4'hF;
			wdata = '1;
		end else begin
			waddr = WW'(slot >> 2);
			wbe   = 4'b0001 << slot[1:0];
			wdata = {4{data_q}};
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			if (mem_we && wbe[i]) mem[waddr][8*i +: 8] <= wdata[8*i +: 8];
		end
		if (cmd.rd_en) rdata_q <= mem[w_q];
	end

	// output register
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			flash_address <= start_q;
			word_index    <= 6'(w_q);
			flash_word    <= rdata_q;
			last_word     <= (w_q == LastWord);
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		stat.act_data    = (action_q == hrsl_pkg::ACT_DATA);
		stat.act_eof     = (action_q == hrsl_pkg::ACT_EOF);
		stat.sector_full = (slot == LastSlot);
		stat.w_last      = (w_q == LastWord);
		stat.out_free    = out_free;
	end

endmodule

// File: design/hrsl_checker.sv
// Port-level checker for the hex record sector loader, with its bind.
module hrsl_checker #(
	parameter int unsigned SECTOR_BYTES = 256
) (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] flash_address,
	input logic [5:0]  word_index,
	input logic [31:0] flash_word,
	input logic        last_word
);

	localparam int unsigned SectorWords = (SECTOR_BYTES + 3) / 4;
	localparam logic [5:0]  LastIndex   = 6'(SectorWords - 1);

	// held beat stays valid
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output beat dropped while stalled");

	// held beat keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(flash_address) && $stable(word_index)
			&& $stable(flash_word) && $stable(last_word))
		else $error("output payload changed while stalled");

	// last flag only on the final word of a sector
	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_word |-> word_index == LastIndex)
		else $error("last_word on wrong word index");

	// a sector write in progress keeps the input side closed
	a_busy_flush: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_word |-> in_stall)
		else $error("input open in the middle of a sector write");

endmodule

bind hex_record_sector_loader hrsl_checker #(
	.SECTOR_BYTES (SECTOR_BYTES)
) u_hrsl_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.flash_address (flash_address),
	.word_index    (word_index),
	.flash_word    (flash_word),
	.last_word     (last_word)
);
